// ----- rtl/tbps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbps_pkg
// Shared widths, codes and interface types of the token bucket shaper.
// ----------------------------------------------------------------------------
package tbps_pkg;

    localparam int QUEUE_DEPTH_DEF  = 32;
    localparam int MAX_RESULTS      = 32;
    localparam int TICKS_PER_SECOND = 100;
    localparam int BYTE_SHIFT       = 3;

    localparam int RATE_W  = 40;
    localparam int BURST_W = 32;
    localparam int LIMIT_W = 24;
    localparam int LEN_W   = 16;
    localparam int QUOT_W  = 34;
    localparam int NEED_W  = LEN_W + BYTE_SHIFT;

    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 5;
    localparam int REG_IDX_LSB = 3;
    localparam int REG_IDX_W   = APB_ADDR_W - REG_IDX_LSB;

    localparam logic [1:0] MODE_ARRIVAL = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_FLUSH   = 2'd2;

    localparam logic [1:0] EV_ACCEPTED = 2'd0;
    localparam logic [1:0] EV_DROPPED  = 2'd1;
    localparam logic [1:0] EV_RELEASED = 2'd2;
    localparam logic [1:0] EV_FLUSHED  = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_AVG_RATE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BURST    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT    = 2'd2;

    typedef struct packed {
        logic [RATE_W-1:0]  avg_rate;
        logic [BURST_W-1:0] burst;
        logic [LIMIT_W-1:0] limit;
        logic               burst_load;
    } cfg_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
        logic rd_en;
    } q_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

// ----- rtl/token_bucket_packet_shaper_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_bucket_packet_shaper_core
// Token bucket shaper over a byte-limited queue of packet lengths.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       sink       in_valid / in_ready     mode, pkt_length
//  out      source     out_valid / out_ready   event_res, length, last
//  cfg      APB slave  psel, penable, pwrite   paddr, pwdata, prdata, pready
//
//  Arrival and flush: the item state after the transfer writes the result register.
//  Tick: start the divider, run its 5 digit steps to done, update the bucket, then
//  per released packet a head read and a check, then close.
//  in_ready is high only while the sequencer is idle.
//  A full output register holds the sequencer until the result is taken.
//  Reset clears the queue pointers, counts, bucket and registers at once.
// ----------------------------------------------------------------------------
module token_bucket_packet_shaper_core #(
    parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       mode,
    input  logic [tbps_pkg::LEN_W-1:0]       pkt_length,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       event_res,
    output logic [tbps_pkg::LEN_W-1:0]       length,
    output logic                             last,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tbps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tbps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tbps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int BURST_W = tbps_pkg::BURST_W;
    localparam int LIMIT_W = tbps_pkg::LIMIT_W;
    localparam int LEN_W   = tbps_pkg::LEN_W;
    localparam int QUOT_W  = tbps_pkg::QUOT_W;
    localparam int SUM_W   = QUOT_W + 1;
    localparam int REL_W   = $clog2(tbps_pkg::MAX_RESULTS + 1);
    localparam logic [REL_W-1:0] REL_MAX = REL_W'(tbps_pkg::MAX_RESULTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ARR   = 3'd1;
    localparam logic [2:0] S_FLUSH = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_CHK   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    tbps_pkg::cfg_t    cfg;
    tbps_pkg::q_ctl_t  q_ctl;
    tbps_pkg::q_stat_t q_stat;
    logic [LEN_W-1:0]  q_rdata;
    logic              div_start;
    logic              div_done;
    logic [QUOT_W-1:0] div_quot;

    logic [2:0]         state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [BURST_W-1:0] bucket_reg, bucket_next;
    logic [LIMIT_W-1:0] total_reg, total_next;
    logic [REL_W-1:0]   rel_cnt_reg, rel_cnt_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [LEN_W-1:0]   pend_len_reg, pend_len_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         ev_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic               last_reg;

    logic               emit;
    logic [1:0]         emit_ev;
    logic [LEN_W-1:0]   emit_len;
    logic               emit_last;
    logic               can_emit;
    logic               arr_drop;
    logic [LIMIT_W:0]   arr_sum;
    logic [SUM_W-1:0]   fill_sum;
    logic [BURST_W-1:0] need;
    logic               rel_ok;

    tbps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbps_div100 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cfg.avg_rate),
        .done     (div_done),
        .quotient (div_quot)
    );

    tbps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (q_ctl),
        .wdata (len_reg),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign can_emit = !out_valid_reg || out_ready;

    assign arr_sum  = {1'b0, total_reg} + {{(LIMIT_W + 1 - LEN_W){1'b0}}, len_reg};
    assign arr_drop = (arr_sum > {1'b0, cfg.limit}) || q_stat.full;
    assign fill_sum = {{(SUM_W - BURST_W){1'b0}}, bucket_reg} + {1'b0, div_quot};
    assign need     = {{(BURST_W - tbps_pkg::NEED_W){1'b0}}, q_rdata,
                       {tbps_pkg::BYTE_SHIFT{1'b0}}};
    assign rel_ok   = (bucket_reg >= need);

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        bucket_next     = bucket_reg;
        total_next      = total_reg;
        rel_cnt_next    = rel_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_len_next   = pend_len_reg;
        q_ctl           = '0;
        div_start       = 1'b0;
        emit            = 1'b0;
        emit_ev         = tbps_pkg::EV_ACCEPTED;
        emit_len        = len_reg;
        emit_last       = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    len_next = pkt_length;
                    case (mode)
                        tbps_pkg::MODE_ARRIVAL: state_next = S_ARR;
                        tbps_pkg::MODE_TICK:
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        tbps_pkg::MODE_FLUSH:   state_next = S_FLUSH;
                        default:                state_next = S_IDLE;
                    endcase
                end
            end
            S_ARR:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (arr_drop)
                    begin
                        emit_ev = tbps_pkg::EV_DROPPED;
                    end
                    else
                    begin
                        q_ctl.push = 1'b1;
                        total_next = arr_sum[LIMIT_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (can_emit)
                begin
                    emit        = 1'b1;
                    emit_ev     = tbps_pkg::EV_FLUSHED;
                    emit_len    = '0;
                    q_ctl.clear = 1'b1;
                    total_next  = '0;
                    state_next  = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (fill_sum > {{(SUM_W - BURST_W){1'b0}}, cfg.burst})
                begin
                    bucket_next = cfg.burst;
                end
                else
                begin
                    bucket_next = fill_sum[BURST_W-1:0];
                end
                rel_cnt_next    = '0;
                pend_valid_next = 1'b0;
                state_next      = S_RD;
            end
            S_RD:
            begin
                if (q_stat.empty || rel_cnt_reg == REL_MAX)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    q_ctl.rd_en = 1'b1;
                    state_next  = S_CHK;
                end
            end
            S_CHK:
            begin
                if (!rel_ok)
                begin
                    state_next = S_FIN;
                end
                else if (!pend_valid_reg || can_emit)
                begin
                    emit            = pend_valid_reg;
                    emit_ev         = tbps_pkg::EV_RELEASED;
                    emit_len        = pend_len_reg;
                    emit_last       = 1'b0;
                    q_ctl.pop       = 1'b1;
                    bucket_next     = bucket_reg - need;
                    total_next      = total_reg - {{(LIMIT_W - LEN_W){1'b0}}, q_rdata};
                    rel_cnt_next    = rel_cnt_reg + 1'b1;
                    pend_valid_next = 1'b1;
                    pend_len_next   = q_rdata;
                    state_next      = S_RD;
                end
            end
            S_FIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (can_emit)
                begin
                    emit            = 1'b1;
                    emit_ev         = tbps_pkg::EV_RELEASED;
                    emit_len        = pend_len_reg;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.burst_load)
        begin
            bucket_next = pwdata[BURST_W-1:0];
        end
    end

    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bucket_reg     <= '0;
            total_reg      <= '0;
            rel_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bucket_reg     <= bucket_next;
            total_reg      <= total_next;
            rel_cnt_reg    <= rel_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        pend_len_reg <= pend_len_next;
        if (emit)
        begin
            ev_reg      <= emit_ev;
            out_len_reg <= emit_len;
            last_reg    <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = ev_reg;
    assign length    = out_len_reg;
    assign last      = last_reg;

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctl.push |-> !q_stat.full)
        else $error("push into full queue");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || out_ready))
        else $error("result overwrites pending output");

    a_rel_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rel_cnt_reg <= REL_MAX)
        else $error("release count beyond limit");

    a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> (total_reg == '0))
        else $error("empty queue with queued bytes");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_ev == tbps_pkg::EV_FLUSHED) |=> (q_stat.empty && total_reg == '0))
        else $error("flush left queue state");

endmodule

// ----- rtl/tbps_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbps_regs
// APB register file: average rate, burst size and buffer limit.
// ----------------------------------------------------------------------------
module tbps_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tbps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tbps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tbps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output tbps_pkg::cfg_t                   cfg
);

    logic [tbps_pkg::RATE_W-1:0]    rate_reg;
    logic [tbps_pkg::BURST_W-1:0]   burst_reg;
    logic [tbps_pkg::LIMIT_W-1:0]   limit_reg;
    logic [tbps_pkg::REG_IDX_W-1:0] idx;
    logic                           wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[tbps_pkg::APB_ADDR_W-1:tbps_pkg::REG_IDX_LSB];
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= '0;
            burst_reg <= '0;
            limit_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                tbps_pkg::REG_AVG_RATE: rate_reg  <= pwdata[tbps_pkg::RATE_W-1:0];
                tbps_pkg::REG_BURST:    burst_reg <= pwdata[tbps_pkg::BURST_W-1:0];
                tbps_pkg::REG_LIMIT:    limit_reg <= pwdata[tbps_pkg::LIMIT_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            tbps_pkg::REG_AVG_RATE:
                prdata = {{(tbps_pkg::APB_DATA_W-tbps_pkg::RATE_W){1'b0}}, rate_reg};
            tbps_pkg::REG_BURST:
                prdata = {{(tbps_pkg::APB_DATA_W-tbps_pkg::BURST_W){1'b0}}, burst_reg};
            tbps_pkg::REG_LIMIT:
                prdata = {{(tbps_pkg::APB_DATA_W-tbps_pkg::LIMIT_W){1'b0}}, limit_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.avg_rate   = rate_reg;
    assign cfg.burst      = burst_reg;
    assign cfg.limit      = limit_reg;
    assign cfg.burst_load = wr_en && (idx == tbps_pkg::REG_BURST);

endmodule

// ----- rtl/tbps_div100.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbps_div100
// Divider by the tick count per second: one rate byte a cycle, each quotient
// digit found by reciprocal multiplication.
// ----------------------------------------------------------------------------
module tbps_div100 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tbps_pkg::RATE_W-1:0]   dividend,
    output logic                          done,
    output logic [tbps_pkg::QUOT_W-1:0]   quotient
);

    localparam int DIGIT_W     = 8;
    localparam int STEPS       = tbps_pkg::RATE_W / DIGIT_W;
    localparam int REM_W       = $clog2(tbps_pkg::TICKS_PER_SECOND);
    localparam int NUM_W       = REM_W + DIGIT_W;
    localparam int RECIP_SHIFT = NUM_W + REM_W;
    localparam int RECIP_W     = RECIP_SHIFT - REM_W + 1;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int CNT_W       = $clog2(STEPS);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + tbps_pkg::TICKS_PER_SECOND - 1)
                 / tbps_pkg::TICKS_PER_SECOND);
    localparam logic [NUM_W-1:0]   DIVISOR   = NUM_W'(tbps_pkg::TICKS_PER_SECOND);
    localparam logic [CNT_W-1:0]   LAST_STEP = CNT_W'(STEPS - 1);

    logic [tbps_pkg::RATE_W-1:0] work_reg, work_next;
    logic [tbps_pkg::QUOT_W-1:0] quot_reg, quot_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [NUM_W-1:0]            num;
    logic [PROD_W-1:0]           prod;
    logic [DIGIT_W-1:0]          qdig;
    logic [NUM_W-1:0]            qdig_scaled;
    logic [NUM_W-1:0]            rem_full;

    assign num         = {rem_reg, work_reg[tbps_pkg::RATE_W-1 -: DIGIT_W]};
    assign prod        = {{RECIP_W{1'b0}}, num} * {{NUM_W{1'b0}}, RECIP};
    assign qdig        = prod[RECIP_SHIFT +: DIGIT_W];
    assign qdig_scaled = {{(NUM_W - DIGIT_W){1'b0}}, qdig} * DIVISOR;
    assign rem_full    = num - qdig_scaled;

    always_comb
    begin
        work_next = work_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = dividend;
            quot_next = '0;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[tbps_pkg::RATE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            quot_next = {quot_reg[tbps_pkg::QUOT_W-DIGIT_W-1:0], qdig};
            rem_next  = rem_full[REM_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ----- rtl/tbps_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbps_queue
// Circular store of packet lengths with head read port and entry count.
// ----------------------------------------------------------------------------
module tbps_queue #(
    parameter int DEPTH = tbps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tbps_pkg::q_ctl_t            ctl,
    input  logic [tbps_pkg::LEN_W-1:0]  wdata,
    output logic [tbps_pkg::LEN_W-1:0]  rdata,
    output tbps_pkg::q_stat_t           stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [tbps_pkg::LEN_W-1:0] mem [DEPTH];
    logic [tbps_pkg::LEN_W-1:0] rdata_reg;
    logic [PTR_W-1:0]           head_reg, head_next;
    logic [PTR_W-1:0]           tail_reg, tail_next;
    logic [CNT_W-1:0]           count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else
        begin
            if (ctl.push)
            begin
                tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
            end
            if (ctl.pop)
            begin
                head_next = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
            end
            if (ctl.push && !ctl.pop)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (ctl.pop && !ctl.push)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

    assign rdata      = rdata_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FULL_CNT);

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the token bucket shaper core against a transaction-level prediction.
// Writes the rate, burst and limit registers over APB between phases. Then
// drives arrivals, ticks, flushes and reserved modes with random gaps on both
// streams, and compares every result transfer in order with the prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import tbps_pkg::*;

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int         CLK_HALF      = 4;
    localparam int         STALL_LIMIT   = 3000;
    localparam int         SETTLE_CYCLES = 150;
    localparam int         PHASE_ITEMS   = 46;
    localparam int         REPORT_MAX    = 10;

    typedef struct packed {
        logic [1:0]       ev;
        logic [LEN_W-1:0] len;
        logic             lst;
    } shaper_event_t;

    class shaper_scoreboard;
        logic [RATE_W-1:0]  avg_rate     = '0;
        logic [BURST_W-1:0] burst        = '0;
        logic [LIMIT_W-1:0] buf_limit    = '0;
        logic [BURST_W-1:0] bucket       = '0;
        logic [LIMIT_W-1:0] queued_bytes = '0;
        logic [LEN_W-1:0]   len_fifo[$];
        shaper_event_t      pending_events[$];
        int unsigned        mismatches   = 0;

        function void apply_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_AVG_RATE: avg_rate = value[RATE_W-1:0];
                REG_BURST:
                begin
                    burst  = value[BURST_W-1:0];
                    bucket = value[BURST_W-1:0];
                end
                REG_LIMIT: buf_limit = value[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void push_event(logic [1:0] ev, logic [LEN_W-1:0] len, logic lst);
            shaper_event_t e;
            e.ev  = ev;
            e.len = len;
            e.lst = lst;
            pending_events.insert(pending_events.size(), e);
        endfunction

        function void predict_item(logic [1:0] m, logic [LEN_W-1:0] len);
            longint unsigned level;
            longint unsigned need;
            int unsigned     n;
            case (m)
                MODE_ARRIVAL:
                begin
                    if (longint'(queued_bytes) + longint'(len) > longint'(buf_limit) ||
                        len_fifo.size() >= QUEUE_DEPTH_DEF)
                    begin
                        push_event(EV_DROPPED, len, 1'b1);
                    end
                    else
                    begin
                        len_fifo.insert(len_fifo.size(), len);
                        queued_bytes = queued_bytes + LIMIT_W'(len);
                        push_event(EV_ACCEPTED, len, 1'b1);
                    end
                end
                MODE_TICK:
                begin
                    level = longint'(bucket) + longint'(avg_rate) / TICKS_PER_SECOND;
                    if (level > longint'(burst))
                        level = longint'(burst);
                    n = 0;
                    while (len_fifo.size() > 0 && n < MAX_RESULTS)
                    begin
                        need = longint'(len_fifo[0]) << BYTE_SHIFT;
                        if (level < need)
                            break;
                        level        = level - need;
                        queued_bytes = queued_bytes - LIMIT_W'(len_fifo[0]);
                        push_event(EV_RELEASED, len_fifo[0], 1'b0);
                        len_fifo.delete(0);
                        n++;
                    end
                    bucket = level[BURST_W-1:0];
                    if (n > 0)
                        pending_events[pending_events.size() - 1].lst = 1'b1;
                end
                MODE_FLUSH:
                begin
                    len_fifo.delete();
                    queued_bytes = '0;
                    push_event(EV_FLUSHED, '0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_event(logic [1:0] ev, logic [LEN_W-1:0] len, logic lst);
            shaper_event_t want;
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result event_res=%0d length=%0d last=%0b",
                             $time, ev, len, lst);
                return;
            end
            want = pending_events[0];
            pending_events.delete(0);
            if (want.ev !== ev || want.len !== len || want.lst !== lst)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: mismatch exp event_res=%0d length=%0d last=%0b, got %0d %0d %0b",
                             $time, want.ev, want.len, want.lst, ev, len, lst);
            end
        endfunction

        function bit drained();
            return pending_events.size() == 0;
        endfunction
    endclass

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [1:0]            mode       = MODE_ARRIVAL;
    logic [LEN_W-1:0]      pkt_length = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [1:0]            event_res;
    logic [LEN_W-1:0]      length;
    logic                  last;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    shaper_scoreboard sb;
    bit               src_no_gaps  = 1'b0;
    bit               sink_no_gaps = 1'b0;

    token_bucket_packet_shaper_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .pkt_length (pkt_length),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_res  (event_res),
        .length     (length),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << REG_IDX_LSB;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.apply_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_shaping(input logic [RATE_W-1:0] rate, input logic [BURST_W-1:0] bkt,
                                 input logic [LIMIT_W-1:0] lim);
        write_reg(REG_AVG_RATE, APB_DATA_W'(rate));
        write_reg(REG_BURST, APB_DATA_W'(bkt));
        write_reg(REG_LIMIT, APB_DATA_W'(lim));
    endtask

    task automatic send_item(input logic [1:0] m, input logic [LEN_W-1:0] len);
        int unsigned gap;
        gap = src_no_gaps ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        pkt_length <= len;
        do @(posedge clk); while (!in_ready);
        sb.predict_item(m, len);
    endtask

    task automatic park_sender();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (!sb.drained())
            @(posedge clk);
    endtask

    task automatic settle();
        park_sender();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return LEN_W'($urandom_range(0, 65535));
            default: return LEN_W'($urandom_range(1, 1600));
        endcase
    endfunction

    task automatic send_fill_and_tick(output int unsigned n_sent);
        int unsigned n_arr;
        n_sent      = 0;
        src_no_gaps = ($urandom_range(0, 3) == 0);
        n_arr       = $urandom_range(1, 40);
        repeat (n_arr)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(2'($urandom_range(0, 3)), LEN_W'($urandom_range(0, 65535)));
            else
                send_item(MODE_ARRIVAL, pick_length());
            n_sent++;
        end
        repeat ($urandom_range(1, 2))
        begin
            send_item(MODE_TICK, LEN_W'($urandom_range(0, 65535)));
            n_sent++;
        end
        if ($urandom_range(0, 5) == 0)
        begin
            send_item(MODE_FLUSH, LEN_W'($urandom_range(0, 65535)));
            n_sent++;
        end
        if ($urandom_range(0, 9) == 0)
            send_item(MODE_RESERVED, LEN_W'($urandom_range(0, 65535)));
    endtask

    initial
    begin : sink
        int unsigned stall;
        forever
        begin
            if ($urandom_range(0, 24) == 0)
                sink_no_gaps = !sink_no_gaps;
            stall = sink_no_gaps ? 0 : $urandom_range(0, 14);
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_event(event_res, length, last);
        end
    end

    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [RATE_W-1:0]  rate_cfg;
        logic [BURST_W-1:0] burst_cfg;
        logic [LIMIT_W-1:0] limit_cfg;
        int unsigned        sent;
        int unsigned        n_seq;
        int unsigned        seq_idx;
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_shaping(RATE_W'(80000), BURST_W'(4000), LIMIT_W'(1000));
        send_item(MODE_ARRIVAL, 16'd0);
        send_item(MODE_ARRIVAL, 16'hFFFF);
        send_item(MODE_ARRIVAL, 16'd100);
        send_item(MODE_ARRIVAL, 16'd200);
        send_item(MODE_ARRIVAL, 16'd50);
        send_item(MODE_TICK, 16'd0);
        send_item(MODE_FLUSH, 16'hFFFF);
        send_item(MODE_RESERVED, 16'hFFFF);
        repeat (4) send_item(MODE_ARRIVAL, 16'd300);
        send_item(MODE_TICK, 16'hA5A5);
        send_item(MODE_FLUSH, 16'd0);
        send_item(MODE_ARRIVAL, 16'd600);
        send_item(MODE_ARRIVAL, 16'd10);
        send_item(MODE_TICK, 16'd0);
        send_item(MODE_TICK, 16'd0);
        send_item(MODE_FLUSH, 16'd0);
        settle();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    rate_cfg  = '0;
                    burst_cfg = '1;
                    limit_cfg = '1;
                end
                1:
                begin
                    rate_cfg  = '1;
                    burst_cfg = BURST_W'($urandom_range(0, 600000));
                    limit_cfg = LIMIT_W'($urandom_range(1000, 200000));
                end
                2:
                begin
                    rate_cfg  = {8'($urandom_range(0, 255)), 32'($urandom())};
                    burst_cfg = '0;
                    limit_cfg = '0;
                end
                3:
                begin
                    rate_cfg  = {8'($urandom_range(0, 255)), 32'($urandom())};
                    burst_cfg = BURST_W'($urandom());
                    limit_cfg = LIMIT_W'($urandom_range(0, 16777215));
                end
                4:
                begin
                    rate_cfg  = RATE_W'($urandom_range(50000, 2000000));
                    burst_cfg = BURST_W'($urandom_range(20000, 600000));
                    limit_cfg = LIMIT_W'($urandom_range(2000, 60000));
                end
                default:
                begin
                    rate_cfg  = RATE_W'($urandom_range(50000, 2000000));
                    burst_cfg = BURST_W'($urandom_range(20000, 600000));
                    limit_cfg = LIMIT_W'($urandom_range(0, 3000));
                end
            endcase
            write_shaping(rate_cfg, burst_cfg, limit_cfg);
            sent    = 0;
            seq_idx = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_fill_and_tick(n_seq);
                sent += n_seq;
                seq_idx++;
                if (seq_idx == 1)
                begin
                    park_sender();
                    wait_drained();
                end
            end
            src_no_gaps = 1'b0;
            settle();
        end

        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
